>>> hw/rtl/blps_pkg.sv
// blps_pkg: shared types and constants of the line pixel stepper
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package blps_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int PITCH_W        = 13;
  localparam int COLOR_W        = 24;
  localparam int ADDR_W         = 24;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 24;

  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(640);
  localparam logic [COLOR_W-1:0] COLOR_RESET = COLOR_W'(24'hFFFFFF);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_PITCH  = 1'b0,
    CFG_DRAW_COLOR = 1'b1
  } cfg_idx_t;

endpackage

>>> hw/rtl/blps_stepper.sv
// blps_stepper: line setup on load and one bresenham step per transfer
// depends on blps_pkg; feeds the pixel stage register to blps_addr
`timescale 1ns / 1ps

module blps_stepper #(
  parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  output logic                  pix_valid,
  input  logic                  pix_ready,
  output logic [COORD_BITS-1:0] pix_x,
  output logic [COORD_BITS-1:0] pix_y,
  output logic                  pix_last
);

  localparam int ERR_W = COORD_BITS + 3;

  logic [COORD_BITS-1:0]   cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]   cur_y_r, cur_y_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic signed [ERR_W-1:0] err_up_r, err_up_nxt;
  logic signed [ERR_W-1:0] err_dn_r, err_dn_nxt;
  logic [COORD_BITS-1:0]   steps_r, steps_nxt;
  logic                    x_neg_r, x_neg_nxt;
  logic                    y_neg_r, y_neg_nxt;
  logic                    y_major_r, y_major_nxt;
  logic                    pix_valid_r, pix_valid_nxt;
  logic [COORD_BITS-1:0]   pix_x_r, pix_x_nxt;
  logic [COORD_BITS-1:0]   pix_y_r, pix_y_nxt;
  logic                    pix_last_r, pix_last_nxt;

  logic                  in_fire;
  logic                  ld_x_neg, ld_y_neg, ld_y_major;
  logic [COORD_BITS-1:0] ld_dx, ld_dy, ld_major, ld_minor;
  logic [ERR_W-1:0]      ld_two_minor, ld_two_major;
  logic                  step_go, minor_step, x_move, y_move;
  logic [COORD_BITS-1:0] step_x, step_y;

  assign in_stall  = pix_valid_r && !pix_ready;
  assign in_fire   = in_valid && !in_stall;
  assign pix_valid = pix_valid_r;
  assign pix_x     = pix_x_r;
  assign pix_y     = pix_y_r;
  assign pix_last  = pix_last_r;

  // line setup
  always_comb begin
    ld_x_neg     = in_x_start > in_x_end;
    ld_y_neg     = in_y_start > in_y_end;
    ld_dx        = ld_x_neg ? in_x_start - in_x_end : in_x_end - in_x_start;
    ld_dy        = ld_y_neg ? in_y_start - in_y_end : in_y_end - in_y_start;
    ld_y_major   = ld_dy > ld_dx;
    ld_major     = ld_y_major ? ld_dy : ld_dx;
    ld_minor     = ld_y_major ? ld_dx : ld_dy;
    ld_two_minor = ERR_W'({ld_minor, 1'b0});
    ld_two_major = ERR_W'({ld_major, 1'b0});
  end

  // one step
  always_comb begin
    step_go    = in_fire && (in_op == blps_pkg::OP_STEP) && (steps_r != '0);
    minor_step = !err_r[ERR_W-1];
    x_move     = y_major_r ? minor_step : 1'b1;
    y_move     = y_major_r ? 1'b1 : minor_step;
    step_x     = cur_x_r;
    step_y     = cur_y_r;
    if (x_move) begin
      step_x = x_neg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
    end
    if (y_move) begin
      step_y = y_neg_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
    end
  end

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    err_up_nxt    = err_up_r;
    err_dn_nxt    = err_dn_r;
    steps_nxt     = steps_r;
    x_neg_nxt     = x_neg_r;
    y_neg_nxt     = y_neg_r;
    y_major_nxt   = y_major_r;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    pix_last_nxt  = pix_last_r;
    pix_valid_nxt = pix_valid_r && !pix_ready;
    if (in_fire && (in_op == blps_pkg::OP_LOAD)) begin
      cur_x_nxt   = in_x_start;
      cur_y_nxt   = in_y_start;
      err_nxt     = ld_two_minor - ERR_W'(ld_major);
      err_up_nxt  = ld_two_minor;
      err_dn_nxt  = ld_two_minor - ld_two_major;
      steps_nxt   = ld_major;
      x_neg_nxt   = ld_x_neg;
      y_neg_nxt   = ld_y_neg;
      y_major_nxt = ld_y_major;
    end else if (step_go) begin
      cur_x_nxt     = step_x;
      cur_y_nxt     = step_y;
      err_nxt       = err_r + (minor_step ? err_dn_r : err_up_r);
      steps_nxt     = steps_r - COORD_BITS'(1);
      pix_valid_nxt = 1'b1;
      pix_x_nxt     = step_x;
      pix_y_nxt     = step_y;
      pix_last_nxt  = steps_r == COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= '0;
      pix_valid_r <= 1'b0;
    end else begin
      steps_r     <= steps_nxt;
      pix_valid_r <= pix_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    err_r      <= err_nxt;
    err_up_r   <= err_up_nxt;
    err_dn_r   <= err_dn_nxt;
    x_neg_r    <= x_neg_nxt;
    y_neg_r    <= y_neg_nxt;
    y_major_r  <= y_major_nxt;
    pix_x_r    <= pix_x_nxt;
    pix_y_r    <= pix_y_nxt;
    pix_last_r <= pix_last_nxt;
  end

endmodule

>>> hw/rtl/blps_addr.sv
// blps_addr: word address multiply-add and the result register
// depends on blps_pkg; takes pixels from blps_stepper
`timescale 1ns / 1ps

module blps_addr #(
  parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  logic [COORD_BITS-1:0]          pix_x,
  input  logic [COORD_BITS-1:0]          pix_y,
  input  logic                           pix_last,
  input  logic [blps_pkg::PITCH_W-1:0]   row_pitch,
  input  logic [blps_pkg::COLOR_W-1:0]   draw_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COORD_BITS-1:0]          out_pixel_x,
  output logic [COORD_BITS-1:0]          out_pixel_y,
  output logic [blps_pkg::ADDR_W-1:0]    out_pixel_address,
  output logic [blps_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic                           out_last_pixel
);

  localparam int PROD_W = COORD_BITS + blps_pkg::PITCH_W;
  localparam int SUM_W  = (PROD_W > blps_pkg::ADDR_W) ? PROD_W : blps_pkg::ADDR_W;

  logic                          out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0]         x_r, y_r;
  logic [blps_pkg::ADDR_W-1:0]   addr_r;
  logic [blps_pkg::COLOR_W-1:0]  color_r;
  logic                          last_r;

  logic                          pix_fire;
  logic [PROD_W-1:0]             prod;
  logic [SUM_W-1:0]              sum;

  assign pix_ready = !out_valid_r || !out_stall;
  assign pix_fire  = pix_valid && pix_ready;

  always_comb begin
    prod = PROD_W'(pix_y) * PROD_W'(row_pitch);
    sum  = SUM_W'(prod) + SUM_W'(pix_x);
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (pix_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      x_r     <= pix_x;
      y_r     <= pix_y;
      addr_r  <= sum[blps_pkg::ADDR_W-1:0];
      color_r <= draw_color;
      last_r  <= pix_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = x_r;
  assign out_pixel_y       = y_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = color_r;
  assign out_last_pixel    = last_r;

endmodule

>>> hw/rtl/bresenham_line_pixel_stepper_top.sv
// Line pixel stepper. A load transfer (op 0) sets up a line from its start to its end
// point and gives no result; each step transfer (op 1) moves one pixel and gives one
// result with the pixel's coordinates, its word address y*row_pitch_words+x (mod 2^24),
// the draw color and a last-pixel flag. The start pixel is never emitted, a zero-length
// line emits nothing, and a step with no active line gives no result. One transfer is
// taken every clock while in_stall is low; a step's result passes the stepper register,
// then the address multiply-add and result register. The user must write configuration
// via cfg_wr_en/cfg_index/cfg_data while the block is idle; it does not enforce this.
// depends on blps_pkg, blps_stepper and blps_addr
`timescale 1ns / 1ps

module bresenham_line_pixel_stepper_top #(
  parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [blps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [blps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [COORD_BITS-1:0]             in_x_start,
  input  logic [COORD_BITS-1:0]             in_y_start,
  input  logic [COORD_BITS-1:0]             in_x_end,
  input  logic [COORD_BITS-1:0]             in_y_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [COORD_BITS-1:0]             out_pixel_x,
  output logic [COORD_BITS-1:0]             out_pixel_y,
  output logic [blps_pkg::ADDR_W-1:0]       out_pixel_address,
  output logic [blps_pkg::COLOR_W-1:0]      out_pixel_color,
  output logic                              out_last_pixel
);

  logic [blps_pkg::PITCH_W-1:0] pitch_r, pitch_nxt;
  logic [blps_pkg::COLOR_W-1:0] color_r, color_nxt;

  logic                  pix_valid, pix_ready, pix_last;
  logic [COORD_BITS-1:0] pix_x, pix_y;

  // configuration registers
  always_comb begin
    pitch_nxt = pitch_r;
    color_nxt = color_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        blps_pkg::CFG_ROW_PITCH: begin
          pitch_nxt = cfg_data[blps_pkg::PITCH_W-1:0];
        end
        blps_pkg::CFG_DRAW_COLOR: begin
          color_nxt = cfg_data[blps_pkg::COLOR_W-1:0];
        end
        default: begin
          pitch_nxt = pitch_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= blps_pkg::PITCH_RESET;
      color_r <= blps_pkg::COLOR_RESET;
    end else begin
      pitch_r <= pitch_nxt;
      color_r <= color_nxt;
    end
  end

  blps_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_x_start (in_x_start),
    .in_y_start (in_y_start),
    .in_x_end   (in_x_end),
    .in_y_end   (in_y_end),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_last   (pix_last)
  );

  blps_addr #(
    .COORD_BITS (COORD_BITS)
  ) u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .pix_valid         (pix_valid),
    .pix_ready         (pix_ready),
    .pix_x             (pix_x),
    .pix_y             (pix_y),
    .pix_last          (pix_last),
    .row_pitch         (pitch_r),
    .draw_color        (color_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last_pixel    (out_last_pixel)
  );

  // a load never puts a pixel into the stepper register
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == blps_pkg::OP_LOAD)) |=> !pix_valid)
    else $error("pixel produced by a load transfer");

  // a pixel waiting for the address stage holds its coordinates
  assert property (@(posedge clk) disable iff (!rst_n)
    (pix_valid && !pix_ready) |=> (pix_valid && $stable(pix_x) && $stable(pix_y)))
    else $error("stepper pixel lost or changed while held");

  // input stalls only because a held pixel cannot advance
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (pix_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

endmodule

>>> bench/tb_bresenham_line_pixel_stepper_top.sv
// testbench for bresenham_line_pixel_stepper_top: directed and random line loads and steps,
// each pixel checked against a built-in line rasterizer over several pitch/color settings
// depends on blps_pkg and the rtl of bresenham_line_pixel_stepper_top
`timescale 1ns / 1ps

module tb_bresenham_line_pixel_stepper_top;

  localparam int CW         = blps_pkg::COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE     = 4;

  typedef struct {
    logic [CW-1:0]                x;
    logic [CW-1:0]                y;
    logic [blps_pkg::ADDR_W-1:0]  addr;
    logic [blps_pkg::COLOR_W-1:0] color;
    logic                         last;
  } pixel_t;

  class line_raster_scoreboard;
    logic [blps_pkg::PITCH_W-1:0] pitch;
    logic [blps_pkg::COLOR_W-1:0] color;
    logic [CW-1:0]      cx, cy;
    int                 err, major, minor, remaining;
    bit                 x_neg, y_neg, y_major;
    pixel_t             expected_pixels[$];
    int                 errors, loads, pixels_checked;

    function new();
      pitch = blps_pkg::PITCH_RESET;
      color = blps_pkg::COLOR_RESET;
      cx = '0;
      cy = '0;
      err = 0;
      major = 0;
      minor = 0;
      remaining = 0;
      x_neg = 0;
      y_neg = 0;
      y_major = 0;
      errors = 0;
      loads = 0;
      pixels_checked = 0;
    endfunction

    function void set_reg(blps_pkg::cfg_idx_t idx, logic [blps_pkg::CFG_DATA_W-1:0] value);
      if (idx == blps_pkg::CFG_ROW_PITCH) begin
        pitch = value[blps_pkg::PITCH_W-1:0];
      end else begin
        color = value[blps_pkg::COLOR_W-1:0];
      end
    endfunction

    function logic [CW-1:0] step_coord(logic [CW-1:0] c, bit neg);
      return neg ? c - 1'b1 : c + 1'b1;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void note_transfer(blps_pkg::op_t op, logic [CW-1:0] xs, logic [CW-1:0] ys,
                                logic [CW-1:0] xe, logic [CW-1:0] ye);
      int     dx, dy;
      bit     diag;
      logic [31:0] sum;
      pixel_t p;
      if (op == blps_pkg::OP_LOAD) begin
        x_neg = xs > xe;
        y_neg = ys > ye;
        dx = x_neg ? int'(xs) - int'(xe) : int'(xe) - int'(xs);
        dy = y_neg ? int'(ys) - int'(ye) : int'(ye) - int'(ys);
        y_major = dy > dx;
        major = y_major ? dy : dx;
        minor = y_major ? dx : dy;
        cx = xs;
        cy = ys;
        err = 2 * minor - major;
        remaining = major;
        loads++;
      end else if (remaining != 0) begin
        diag = err >= 0;
        if (diag) begin
          err += 2 * (minor - major);
        end else begin
          err += 2 * minor;
        end
        if (y_major) begin
          cy = step_coord(cy, y_neg);
          if (diag) cx = step_coord(cx, x_neg);
        end else begin
          cx = step_coord(cx, x_neg);
          if (diag) cy = step_coord(cy, y_neg);
        end
        remaining--;
        sum = 32'(cy) * 32'(pitch) + 32'(cx);
        p.x = cx;
        p.y = cy;
        p.addr = sum[blps_pkg::ADDR_W-1:0];
        p.color = color;
        p.last = (remaining == 0);
        expected_pixels.push_back(p);
      end
    endfunction

    function void check_pixel(logic [CW-1:0] x, logic [CW-1:0] y,
                              logic [blps_pkg::ADDR_W-1:0] addr,
                              logic [blps_pkg::COLOR_W-1:0] col, logic last);
      pixel_t p;
      if (expected_pixels.size() == 0) begin
        $error("pixel transfer with none expected: x %0d y %0d", x, y);
        errors++;
        return;
      end
      p = expected_pixels.pop_front();
      pixels_checked++;
      if (x !== p.x) begin
        $error("pixel_x mismatch: expected %0d, actual %0d", p.x, x);
        errors++;
      end
      if (y !== p.y) begin
        $error("pixel_y mismatch: expected %0d, actual %0d", p.y, y);
        errors++;
      end
      if (addr !== p.addr) begin
        $error("pixel_address mismatch: expected %0h, actual %0h", p.addr, addr);
        errors++;
      end
      if (col !== p.color) begin
        $error("pixel_color mismatch: expected %0h, actual %0h", p.color, col);
        errors++;
      end
      if (last !== p.last) begin
        $error("last_pixel mismatch: expected %0b, actual %0b", p.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [blps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [blps_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_op;
  logic [CW-1:0]                   in_x_start, in_y_start, in_x_end, in_y_end;
  logic                            out_valid;
  logic                            out_stall;
  logic [CW-1:0]                   out_pixel_x, out_pixel_y;
  logic [blps_pkg::ADDR_W-1:0]     out_pixel_address;
  logic [blps_pkg::COLOR_W-1:0]    out_pixel_color;
  logic                            out_last_pixel;

  line_raster_scoreboard sb;
  bit gaps_on;
  bit stall_on;
  int stall_left;
  int sent;
  int settings;
  int cycles;

  bresenham_line_pixel_stepper_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_x_start        (in_x_start),
    .in_y_start        (in_y_start),
    .in_x_end          (in_x_end),
    .in_y_end          (in_y_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last_pixel    (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bresenham_line_pixel_stepper_top test failed");
      $finish;
    end
  end

  // result side: check accepted pixels, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pixel(out_pixel_x, out_pixel_y, out_pixel_address, out_pixel_color,
                     out_last_pixel);
    end
    if (stall_left == 0 && stall_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  task automatic send_item(blps_pkg::op_t op, logic [CW-1:0] xs, logic [CW-1:0] ys,
                           logic [CW-1:0] xe, logic [CW-1:0] ye);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end   <= xe;
    in_y_end   <= ye;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(op, xs, ys, xe, ye);
    sent++;
  endtask

  task automatic send_step();
    send_item(blps_pkg::OP_STEP, CW'($urandom()), CW'($urandom()), CW'($urandom()),
              CW'($urandom()));
  endtask

  task automatic draw_line(int xs, int ys, int xe, int ye, int steps);
    send_item(blps_pkg::OP_LOAD, CW'(xs), CW'(ys), CW'(xe), CW'(ye));
    repeat (steps) send_step();
  endtask

  // stop sending and let every expected pixel arrive
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_regs(logic [blps_pkg::PITCH_W-1:0] pitch,
                            logic [blps_pkg::COLOR_W-1:0] col);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= blps_pkg::CFG_ROW_PITCH;
    cfg_data  <= blps_pkg::CFG_DATA_W'(pitch);
    @(posedge clk);
    sb.set_reg(blps_pkg::CFG_ROW_PITCH, blps_pkg::CFG_DATA_W'(pitch));
    cfg_index <= blps_pkg::CFG_DRAW_COLOR;
    cfg_data  <= col;
    @(posedge clk);
    sb.set_reg(blps_pkg::CFG_DRAW_COLOR, col);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return (1 << CW) - 1;
      default: return int'($urandom_range(0, (1 << CW) - 1));
    endcase
  endfunction

  function automatic int near_coord(int c, int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > (1 << CW) - 1) v = (1 << CW) - 1;
    return v;
  endfunction

  task automatic random_sequence(bit quiet);
    int xs, ys, xe, ye, len, span, steps;
    gaps_on  = !quiet && $urandom_range(0, 3) != 0;
    stall_on = !quiet && $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 9))
      8: send_step();
      9: send_item(blps_pkg::OP_LOAD, CW'($urandom()), CW'($urandom()), CW'($urandom()),
                   CW'($urandom()));
      7: begin
        // long line, only partly walked before the next load replaces it
        draw_line(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                  $urandom_range(1, 24));
      end
      default: begin
        span = ($urandom_range(0, 4) == 0) ? 40 : 12;
        xs = pick_coord();
        ys = pick_coord();
        xe = near_coord(xs, span);
        ye = near_coord(ys, span);
        len = (xe > xs ? xe - xs : xs - xe);
        if ((ye > ys ? ye - ys : ys - ye) > len) len = (ye > ys ? ye - ys : ys - ye);
        if ($urandom_range(0, 4) == 0) begin
          steps = $urandom_range(0, len);
        end else begin
          steps = len + $urandom_range(0, 2);
        end
        draw_line(xs, ys, xe, ye, steps);
      end
    endcase
  endtask

  initial begin
    logic [blps_pkg::PITCH_W-1:0] pitches[5];
    logic [blps_pkg::COLOR_W-1:0] colors[5];
    int target;
    sb = new();
    rst_n      <= 1'b0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= blps_pkg::CFG_ROW_PITCH;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_op      <= blps_pkg::OP_LOAD;
    in_x_start <= '0;
    in_y_start <= '0;
    in_x_end   <= '0;
    in_y_end   <= '0;
    out_stall  <= 1'b0;
    gaps_on  = 1;
    stall_on = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines under the reset register values
    send_step();
    draw_line(100, 200, 100, 200, 1);
    draw_line(4095, 4095, 0, 0, 2);
    draw_line(0, 4095, 4095, 0, 1);
    draw_line(10, 10, 12, 15, 6);
    draw_line(20, 5, 17, 4, 3);
    draw_line(7, 9, 7, 6, 3);

    pitches = '{13'd0, 13'd1, 13'd4096, 13'd8191,
                blps_pkg::PITCH_W'($urandom_range(1, 4096))};
    colors  = '{blps_pkg::COLOR_W'($urandom()), 24'h000000, blps_pkg::COLOR_W'($urandom()),
                24'hFFFFFF, blps_pkg::COLOR_W'($urandom())};
    for (int ph = 0; ph < 5; ph++) begin
      write_regs(pitches[ph], colors[ph]);
      target = sent + 80;
      while (sent < target) begin
        random_sequence(ph == 4);
        if (ph == 1 && sent >= target - 40 && sent < target - 30) drain();
      end
    end

    gaps_on  = 0;
    stall_on = 0;
    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d transfers with %0d line loads, %0d pixels checked",
             sent, sb.loads, sb.pixels_checked);
    $display("register settings applied: %0d, including zero and full-scale pitch", settings);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bresenham_line_pixel_stepper_top test passed");
    end else begin
      $display("bresenham_line_pixel_stepper_top test failed");
    end
    $finish;
  end

endmodule
